[src/simple_pattern_matcher_macros.svh]
// Assertion macros for the pattern matcher.
`ifndef SIMPLE_PATTERN_MATCHER_MACROS_SVH
`define SIMPLE_PATTERN_MATCHER_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define SPM_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define SPM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/spm_pkg.sv]
package spm_pkg;

   // Request codes.
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_BYTE = 2'd1;
   localparam logic [1:0] REQ_END  = 2'd2;
   localparam logic [1:0] REQ_NOP  = 2'd3;

   // Node kinds.
   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_STAR  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   // A high bound of zero marks a single byte.
   localparam logic [7:0] SINGLE_MARK = 8'd0;

   // Configuration register indexes.
   localparam logic [0:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [0:0] CSR_ANCHORED   = 1'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] node_index;
      logic [2:0] slot_index;
      logic [7:0] range_low;
      logic [7:0] range_high;
      logic       slot_used;
      logic [1:0] node_kind;
      logic       node_negate;
      logic [7:0] text_byte;
   } req_type_type;

   typedef struct packed {
      logic        found;
      logic [15:0] match_start;
      logic [15:0] match_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SCAN,
      ST_LOOK,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Range scanner command and status.
   typedef struct packed {
      logic start;
      logic clear;
   } scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } scan_sts_type;

endpackage

[src/spm_range_scan.sv]
// Walks the range slots of one node, one slot per cycle, comparing a byte.
module spm_range_scan #(
   parameter int MAX_NODES  = 16,
   parameter int MAX_RANGES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_NODES)-1:0]    wr_node,
   input  logic [$clog2(MAX_RANGES+1)-1:0] wr_slot,
   input  logic [16:0]                     wr_data,
   input  logic [$clog2(MAX_NODES)-1:0]    node,
   input  logic [7:0]                      value,
   input  spm_pkg::scan_ctl_type           ctl,
   output spm_pkg::scan_sts_type           sts
);
   import spm_pkg::*;

   localparam int SB = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CB = $clog2(MAX_RANGES + 1);
   localparam int DEPTH = MAX_NODES * MAX_RANGES;
   localparam int AB = $clog2(DEPTH);

   logic [16:0]   mem [DEPTH];
   logic [16:0]   rd_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          rdv_ff, rdv_in;
   logic          busy_ff, busy_in;
   logic          hit_ff, hit_in;
   logic [AB-1:0] wr_addr, rd_addr;
   logic          rd_hit;
   logic [SB-1:0] slot_lo;

   assign slot_lo = cnt_ff[SB-1:0];
   assign wr_addr = AB'(({{AB{1'b0}}, wr_node} * AB'(MAX_RANGES))
                      + AB'(wr_slot[SB-1:0]));
   assign rd_addr = AB'(({{AB{1'b0}}, node} * AB'(MAX_RANGES)) + AB'(slot_lo));

   // Range table memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Compare of the slot read last cycle.
   always_comb begin
      rd_hit = 1'b0;
      if (rd_ff[16]) begin
         if (rd_ff[15:8] == SINGLE_MARK) begin
            rd_hit = (value == rd_ff[7:0]);
         end else begin
            rd_hit = (value >= rd_ff[7:0]) && (value <= rd_ff[15:8]);
         end
      end
   end

   // Slot sequencing.
   always_comb begin
      cnt_in  = cnt_ff;
      rdv_in  = 1'b0;
      busy_in = busy_ff;
      hit_in  = hit_ff;
      if (ctl.start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         hit_in  = 1'b0;
      end else if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (busy_ff) begin
         if (rdv_ff && rd_hit) begin
            hit_in = 1'b1;
         end
         if (cnt_ff == CB'(MAX_RANGES)) begin
            busy_in = rdv_ff;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            rdv_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rdv_ff  <= 1'b0;
         busy_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         rdv_ff  <= rdv_in;
         busy_ff <= busy_in;
         hit_ff  <= hit_in;
      end
   end

   assign sts.busy = busy_ff || ctl.start;
   assign sts.hit  = hit_ff;
endmodule

[src/simple_pattern_matcher.sv]
// Pattern matcher over a loaded table of pattern nodes.
// The req_ channel carries load, text byte, no-op and end-of-text beats; rsp_
// returns one beat (found, start, length) for each end-of-text beat.
// Configuration writes (node count, anchored) use the csr_ port while idle.
// A load beat leaves the block idle, so loads can follow back to back. A text
// byte walks marks and nodes through one shared range scanner that reads one
// slot per cycle: each plain or star node test, and each lookahead test of a
// star, scans all MAX_RANGES slots of its node, a mark is passed in a step
// state, and the block returns to idle to accept the next beat.
// End of text passes through a finish state before the response shows; the
// next beat is accepted in the cycle after the response is taken.
// One beat is in work at a time; req_stall is high while busy.
// Synchronous reset clears the search state and configuration; the range
// table and node flags hold no value until loaded.
// While a response waits under rsp_stall it holds and no request is accepted.
`include "simple_pattern_matcher_macros.svh"
module simple_pattern_matcher #(
   parameter int MAX_NODES  = 16,
   parameter int MAX_RANGES = 8,
   parameter int POS_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spm_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spm_pkg::rsp_type      rsp_data,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [4:0]            csr_data
);
   import spm_pkg::*;

   localparam int NB = $clog2(MAX_NODES);
   localparam int CNB = $clog2(MAX_NODES + 1);
   localparam int CB = $clog2(MAX_RANGES + 1);

   state_type state_ff, state_in;
   logic [4:0]          node_count_ff;
   logic                anchored_ff;
   logic [2:0]          flags [MAX_NODES];
   logic [CNB-1:0]      cur_ff, cur_in;
   logic [CNB-1:0]      look_ff, look_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, start_ff, start_in, stop_ff, stop_in;
   logic                star_ff, star_in, fail_ff, fail_in, done_ff, done_in;
   logic [7:0]          byte_ff;
   logic                star_hit_ff, star_hit_in;
   rsp_type             rsp_ff, rsp_in;
   logic [CNB-1:0]      n_use;
   logic                accept;
   scan_ctl_type        ctl;
   scan_sts_type        sts;
   logic [NB-1:0]       scan_node;
   logic [1:0]          cur_kind, look_kind;
   logic                cur_neg;
   logic [CNB-1:0]      fin_cur;
   logic [POS_BITS-1:0] fin_end;

   assign n_use = (32'(node_count_ff) > MAX_NODES) ? CNB'(MAX_NODES) : CNB'(node_count_ff);
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = rsp_ff;

   assign cur_kind  = flags[cur_ff[NB-1:0]][1:0];
   assign cur_neg   = flags[cur_ff[NB-1:0]][2];
   assign look_kind = flags[look_ff[NB-1:0]][1:0];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         anchored_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_data;
            CSR_ANCHORED:   anchored_ff   <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // Node flags, written by load beats.
   always_ff @(posedge clock) begin
      if (accept && req_data.req_type == REQ_LOAD && 32'(req_data.node_index) < MAX_NODES
          && 32'(req_data.slot_index) < MAX_RANGES) begin
         flags[req_data.node_index[NB-1:0]] <= {req_data.node_negate, req_data.node_kind};
      end
      if (accept) begin
         byte_ff <= req_data.text_byte;
      end
   end

   spm_range_scan #(.MAX_NODES(MAX_NODES), .MAX_RANGES(MAX_RANGES)) u_scan (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_data.req_type == REQ_LOAD
                && 32'(req_data.node_index) < MAX_NODES
                && 32'(req_data.slot_index) < MAX_RANGES),
      .wr_node (req_data.node_index[NB-1:0]),
      .wr_slot (CB'(req_data.slot_index)),
      .wr_data ({req_data.slot_used, req_data.range_high, req_data.range_low}),
      .node    (scan_node),
      .value   (byte_ff),
      .ctl     (ctl),
      .sts     (sts)
   );

   assign scan_node = (state_ff == ST_LOOK) ? look_ff[NB-1:0] : cur_ff[NB-1:0];

   // End-of-text evaluation of the node reached.
   always_comb begin
      fin_cur = cur_ff;
      if (star_ff && cur_ff < n_use) begin
         fin_cur = cur_ff + 1'b1;
      end
      fin_end = (stop_ff != '0) ? stop_ff : pos_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.req_type == REQ_BYTE) begin
               state_in = (fail_ff || done_ff) ? ST_IDLE : ST_STEP;
            end else if (accept && req_data.req_type == REQ_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_STEP: begin
            if (cur_ff >= n_use) begin
               state_in = ST_IDLE;
            end else if (cur_kind == KIND_STAR || cur_kind == KIND_PLAIN) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.busy) begin
               if (cur_kind == KIND_STAR && sts.hit) begin
                  state_in = ST_LOOK;
               end else if (cur_kind == KIND_STAR) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOOK: begin
            if (look_ff >= n_use) begin
               state_in = ST_IDLE;
            end else if (look_kind == KIND_PLAIN || look_kind == KIND_STAR) begin
               if (!sts.busy) begin
                  state_in = sts.hit ? ST_STEP : ST_IDLE;
               end
            end
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    state_in = rsp_stall ? ST_OUT : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and scanner control.
   always_comb begin
      cur_in      = cur_ff;
      look_in     = look_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      stop_in     = stop_ff;
      star_in     = star_ff;
      fail_in     = fail_ff;
      done_in     = done_ff;
      star_hit_in = star_hit_ff;
      rsp_in      = rsp_ff;
      ctl         = '0;
      case (state_ff)
         ST_STEP: begin
            if (cur_ff >= n_use) begin
               done_in = 1'b1;
            end else if (cur_kind == KIND_START) begin
               start_in = pos_ff;
               cur_in   = cur_ff + 1'b1;
            end else if (cur_kind == KIND_STOP) begin
               stop_in = pos_ff;
               cur_in  = cur_ff + 1'b1;
            end else begin
               ctl.start = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!sts.busy) begin
               if (cur_kind == KIND_STAR) begin
                  if (sts.hit) begin
                     look_in = cur_ff + 1'b1;
                     ctl.clear = 1'b1;
                  end else begin
                     star_in = 1'b0;
                     cur_in  = cur_ff + 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (sts.hit != cur_neg) begin
                     cur_in = cur_ff + 1'b1;
                  end else if (!anchored_ff) begin
                     cur_in   = '0;
                     start_in = pos_ff + 1'b1;
                  end else begin
                     fail_in = 1'b1;
                     pos_in  = pos_ff;
                  end
               end
            end
         end
         ST_LOOK: begin
            if (look_ff >= n_use) begin
               star_in = 1'b1;
               pos_in  = pos_ff + 1'b1;
            end else if (look_kind == KIND_PLAIN || look_kind == KIND_STAR) begin
               if (star_hit_ff == 1'b0) begin
                  ctl.start   = 1'b1;
                  star_hit_in = 1'b1;
               end else if (!sts.busy) begin
                  star_hit_in = 1'b0;
                  if (sts.hit) begin
                     star_in = 1'b0;
                     cur_in  = cur_ff + 1'b1;
                  end else begin
                     star_in = 1'b1;
                     pos_in  = pos_ff + 1'b1;
                  end
               end
            end else begin
               look_in = look_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_in = '0;
            if (!fail_ff && (fin_cur >= n_use
                || flags[fin_cur[NB-1:0]][1:0] == KIND_STAR
                || (fin_cur + 1'b1 == n_use && flags[fin_cur[NB-1:0]][1:0] == KIND_STOP))) begin
               rsp_in.found        = 1'b1;
               rsp_in.match_start  = 16'(start_ff);
               rsp_in.match_length = (fin_end >= start_ff) ? 16'(fin_end - start_ff) : '0;
            end
            cur_in   = '0;
            pos_in   = '0;
            start_in = '0;
            stop_in  = '0;
            star_in  = 1'b0;
            fail_in  = 1'b0;
            done_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_ff      <= '0;
         look_ff     <= '0;
         pos_ff      <= '0;
         start_ff    <= '0;
         stop_ff     <= '0;
         star_ff     <= 1'b0;
         fail_ff     <= 1'b0;
         done_ff     <= 1'b0;
         star_hit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         look_ff     <= look_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         stop_ff     <= stop_in;
         star_ff     <= star_in;
         fail_ff     <= fail_in;
         done_ff     <= done_in;
         star_hit_ff <= star_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // A response is held until taken, and requests wait meanwhile.
   `SPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `SPM_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall)
   `SPM_ASSERT_NEXT(a_fin_out, clock, reset, state_ff == ST_FINISH, rsp_valid)
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   import spm_pkg::*;

   localparam int NODES      = 16;
   localparam int SLOTS      = 8;
   localparam int SETTLE     = 400;
   localparam int CYCLE_CAP  = 1500000;
   localparam int RAND_ITEMS = 890;

   // Keeps its own copy of the pattern table and search state and queues the
   // match beat expected for each end of text.
   class match_board;
      logic [7:0]  lo_tab[NODES][SLOTS];
      logic [7:0]  hi_tab[NODES][SLOTS];
      logic        used_tab[NODES][SLOTS];
      logic [1:0]  kind_tab[NODES];
      logic        neg_tab[NODES];
      int          node_count;
      bit          anchored;
      int          cur;
      logic [15:0] pos;
      logic [15:0] start_pos;
      logic [15:0] stop_pos;
      bit          in_star;
      bit          failed;
      bit          done;
      rsp_type     expected_matches[$];
      int          errors;

      function new();
         errors = 0;
         node_count = 0;
         anchored = 0;
         clear();
      endfunction

      function void clear();
         cur = 0;
         pos = 0;
         start_pos = 0;
         stop_pos = 0;
         in_star = 0;
         failed = 0;
         done = 0;
      endfunction

      function int nodes_in_use();
         return (node_count > NODES) ? NODES : node_count;
      endfunction

      function bit accepts(int nd, logic [7:0] c);
         for (int s = 0; s < SLOTS; s++) begin
            if (used_tab[nd][s]) begin
               if (hi_tab[nd][s] == SINGLE_MARK) begin
                  if (c == lo_tab[nd][s]) return 1;
               end else if (c >= lo_tab[nd][s] && c <= hi_tab[nd][s]) begin
                  return 1;
               end
            end
         end
         return 0;
      endfunction

      // A star gives way as soon as the next character node takes the byte.
      function bit next_accepts(int nd, int n, logic [7:0] c);
         for (int j = nd + 1; j < n; j++) begin
            if (kind_tab[j] == KIND_PLAIN || kind_tab[j] == KIND_STAR) return accepts(j, c);
         end
         return 0;
      endfunction

      function void take_byte(logic [7:0] c);
         int n;
         bit pass;
         n = nodes_in_use();
         if (failed || done) return;
         while (1) begin
            if (cur >= n) begin
               done = 1;
               return;
            end
            case (kind_tab[cur])
               KIND_STAR: begin
                  if (accepts(cur, c) && !next_accepts(cur, n, c)) begin
                     in_star = 1;
                     pos = pos + 16'd1;
                     return;
                  end
                  in_star = 0;
                  cur++;
               end
               KIND_START: begin
                  start_pos = pos;
                  cur++;
               end
               KIND_STOP: begin
                  stop_pos = pos;
                  cur++;
               end
               default: begin
                  pass = accepts(cur, c) != neg_tab[cur];
                  if (pass) begin
                     cur++;
                  end else if (!anchored) begin
                     cur = 0;
                     start_pos = pos + 16'd1;
                  end else begin
                     failed = 1;
                     return;
                  end
                  pos = pos + 16'd1;
                  return;
               end
            endcase
         end
      endfunction

      function void finish_text();
         int      n;
         int      c;
         bit      hit;
         rsp_type r;
         logic [15:0] stop_at;
         n = nodes_in_use();
         c = cur;
         hit = 0;
         r = '0;
         if (!failed) begin
            if (in_star && c < n) c++;
            hit = (c >= n) || (kind_tab[c] == KIND_STAR) ||
                  (c + 1 == n && kind_tab[c] == KIND_STOP);
         end
         if (hit) begin
            stop_at = (stop_pos != 0) ? stop_pos : pos;
            r.found = 1;
            r.match_start = start_pos;
            r.match_length = (stop_at >= start_pos) ? stop_at - start_pos : 16'd0;
         end
         expected_matches = {expected_matches, r};
         clear();
      endfunction

      function void note_beat(req_type_type b);
         case (b.req_type)
            REQ_LOAD: begin
               lo_tab[b.node_index][b.slot_index] = b.range_low;
               hi_tab[b.node_index][b.slot_index] = b.range_high;
               used_tab[b.node_index][b.slot_index] = b.slot_used;
               kind_tab[b.node_index] = b.node_kind;
               neg_tab[b.node_index] = b.node_negate;
            end
            REQ_BYTE: take_byte(b.text_byte);
            REQ_END:  finish_text();
            default: ;
         endcase
      endfunction

      function void check_beat(rsp_type a);
         rsp_type e;
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected match beat %h", $time, a);
            errors++;
            return;
         end
         e = expected_matches.pop_front();
         if (a.found !== e.found) begin
            $display("%0t: found expected %0d actual %0d", $time, e.found, a.found);
            errors++;
         end
         if (a.match_start !== e.match_start) begin
            $display("%0t: match_start expected %0d actual %0d", $time, e.match_start,
                     a.match_start);
            errors++;
         end
         if (a.match_length !== e.match_length) begin
            $display("%0t: match_length expected %0d actual %0d", $time, e.match_length,
                     a.match_length);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_type      rsp_data;
   logic         csr_write = 0;
   logic [0:0]   csr_index = CSR_NODE_COUNT;
   logic [4:0]   csr_data = '0;

   match_board board = new();
   bit         quiet = 0;
   int         cycles = 0;

   simple_pattern_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: stall at random before each beat, then take one beat.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall = 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         board.check_beat(rsp_data);
         @(negedge clock);
      end
   end

   // Sends one request beat; called at a falling edge, returns at one.
   task automatic send_beat(req_type_type b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_data = b;
      do @(posedge clock); while (req_stall);
      board.note_beat(b);
      @(negedge clock);
   endtask

   // Lets the block drain before a register write.
   task automatic wait_idle();
      req_valid = 0;
      while (board.expected_matches.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [4:0] val);
      wait_idle();
      csr_write = 1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 0;
      if (idx == CSR_NODE_COUNT) board.node_count = int'(val);
      else board.anchored = val[0];
   endtask

   task automatic load_slot(int nd, int sl, logic [1:0] kind, logic neg,
                            logic [7:0] lo, logic [7:0] hi, logic used);
      req_type_type b;
      b = '0;
      b.req_type = REQ_LOAD;
      b.node_index = 4'(nd);
      b.slot_index = 3'(sl);
      b.range_low = lo;
      b.range_high = hi;
      b.slot_used = used;
      b.node_kind = kind;
      b.node_negate = neg;
      b.text_byte = 8'($urandom);
      send_beat(b);
   endtask

   task automatic send_text(string s);
      req_type_type b;
      for (int i = 0; i < s.len(); i++) begin
         b = req_type_type'({$urandom, $urandom});
         b.req_type = REQ_BYTE;
         b.text_byte = s[i];
         send_beat(b);
      end
      b = req_type_type'({$urandom, $urandom});
      b.req_type = REQ_END;
      send_beat(b);
   endtask

   // Bytes mostly come from a small alphabet so that patterns really match.
   function automatic logic [7:0] pick_char();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(0, 4));
   endfunction

   initial begin
      int           items;
      int           len;
      int           k;
      int           nd;
      logic [7:0]   lo;
      logic [7:0]   hi;
      req_type_type b;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Fill the whole table so that no entry is ever read unwritten.
      for (int n = 0; n < NODES; n++) begin
         for (int s = 0; s < SLOTS; s++) begin
            load_slot(n, s, KIND_PLAIN, 1'b0, 8'($urandom), 8'($urandom), 1'b0);
         end
      end

      // Directed: start mark, 'a'..'c', star of 'x', not 'y', stop mark.
      load_slot(0, 0, KIND_START, 1'b0, "a", 8'd0, 1'b1);
      load_slot(1, 0, KIND_PLAIN, 1'b0, "a", "c", 1'b1);
      load_slot(2, 0, KIND_STAR, 1'b1, "x", 8'd0, 1'b1);
      load_slot(3, 0, KIND_PLAIN, 1'b1, "y", 8'd0, 1'b1);
      load_slot(4, 0, KIND_STOP, 1'b0, 8'hff, 8'hff, 1'b1);
      write_csr(CSR_NODE_COUNT, 5'd5);
      send_text("zbxxq");
      send_text("bxx");
      send_text("");
      send_text("aqzzz");
      b = '1;
      send_beat(b);
      write_csr(CSR_ANCHORED, 5'd1);
      send_text("zb");
      send_text("cq");
      write_csr(CSR_NODE_COUNT, 5'd1);
      send_text("");
      write_csr(CSR_NODE_COUNT, 5'd0);
      send_text("a");
      write_csr(CSR_NODE_COUNT, 5'd31);
      write_csr(CSR_ANCHORED, 5'd0);
      send_text("a");

      // Random sessions: a few table edits, then one text.
      items = 0;
      while (items < RAND_ITEMS) begin
         quiet = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 5))
               0:       write_csr(CSR_NODE_COUNT, 5'd0);
               1:       write_csr(CSR_NODE_COUNT, 5'd16);
               2:       write_csr(CSR_NODE_COUNT, 5'($urandom_range(17, 31)));
               default: write_csr(CSR_NODE_COUNT, 5'($urandom_range(1, 6)));
            endcase
         end
         if ($urandom_range(0, 5) == 0) write_csr(CSR_ANCHORED, 5'($urandom_range(0, 1)));
         k = $urandom_range(0, 3);
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               b = req_type_type'({$urandom, $urandom});
               b.req_type = REQ_LOAD;
               send_beat(b);
            end else begin
               nd = $urandom_range(0, 6);
               lo = pick_char();
               hi = ($urandom_range(0, 1) == 0) ? SINGLE_MARK : 8'(lo + $urandom_range(0, 2));
               load_slot(nd, $urandom_range(0, 2), 2'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0), lo, hi, ($urandom_range(0, 7) != 0));
            end
            items++;
         end
         len = $urandom_range(0, 10);
         for (int i = 0; i < len; i++) begin
            b = req_type_type'({$urandom, $urandom});
            b.req_type = REQ_BYTE;
            b.text_byte = pick_char();
            send_beat(b);
         end
         if ($urandom_range(0, 15) == 0) begin
            b = req_type_type'({$urandom, $urandom});
            b.req_type = REQ_NOP;
            send_beat(b);
         end
         b = req_type_type'({$urandom, $urandom});
         b.req_type = REQ_END;
         send_beat(b);
         items += len + 1;
      end
      req_valid = 0;

      while (board.expected_matches.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (board.expected_matches.size() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[simple_pattern_matcher.f]
+incdir+src
src/spm_pkg.sv
src/spm_range_scan.sv
src/simple_pattern_matcher.sv
bench/tb.sv
